// ===== design/het_pkg.sv =====
// package for the hann edge taper: widths, register codes, stage types and the cosine table
`default_nettype none

package het_pkg;

   localparam int SAMPLE_BITS     = 24;
   localparam int POS_BITS        = 16;
   localparam int REG_BITS        = 17;
   localparam int FRAC_BITS       = 16;
   localparam int PROD_BITS       = 2 * REG_BITS;
   localparam int COS_TABLE_DEPTH = 1024;
   localparam int COS_IDX_BITS    = $clog2(COS_TABLE_DEPTH);
   localparam int COS_BITS        = 18;
   localparam int PHASE_FRAC_BITS = 16;
   localparam int PHASE_BITS      = COS_IDX_BITS + PHASE_FRAC_BITS;
   localparam int DIV_STEPS       = PHASE_BITS + 1;
   localparam int REM_BITS        = REG_BITS + 1;
   localparam int COEF_BITS       = 17;
   localparam int HH_BITS         = 2 * COEF_BITS - 1;
   localparam int MUL_BITS        = SAMPLE_BITS + HH_BITS;
   localparam int ROUND_FRAC      = 1 << (PHASE_FRAC_BITS - 1);

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [1:0] REG_TRACE_LENGTH   = 2'd0;
   localparam logic [1:0] REG_LEFT_FRACTION  = 2'd1;
   localparam logic [1:0] REG_RIGHT_FRACTION = 2'd2;

   localparam logic [REG_BITS-1:0] TRACE_LENGTH_RESET = 17'd1024;
   localparam logic [REG_BITS-1:0] FRACTION_RESET     = 17'd3277;
   localparam logic [REG_BITS-1:0] MAX_TRACE_LEN      = 17'd65536;

   localparam logic [COEF_BITS-1:0] COEF_ONE = 17'd65536;
   localparam logic [COS_BITS-1:0]  BIAS_MAX = 18'd131072;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic [COS_BITS-1:0] cos_rom_type [COS_TABLE_DEPTH];

   typedef struct packed {
      logic                   valid;
      logic                   neg;
      logic [SAMPLE_BITS-1:0] mag;
      logic                   on_l;
      logic                   on_r;
   } carry_type;

   typedef struct packed {
      logic                          valid;
      logic signed [SAMPLE_BITS-1:0] value;
      logic [POS_BITS-1:0]           pos;
      logic [PROD_BITS-1:0]          prod_l;
      logic [PROD_BITS-1:0]          prod_r;
   } accept_stage_type;

   typedef struct packed {
      logic [REM_BITS-1:0]   rem;
      logic [REG_BITS-1:0]   den;
      logic [PHASE_BITS-1:0] quo;
   } div_side_type;

   typedef struct packed {
      carry_type    c;
      div_side_type l;
      div_side_type r;
   } div_stage_type;

   typedef struct packed {
      logic [COS_BITS-1:0]        a;
      logic [COS_BITS-1:0]        b;
      logic [PHASE_FRAC_BITS-1:0] frac;
   } rom_side_type;

   typedef struct packed {
      carry_type    c;
      rom_side_type l;
      rom_side_type r;
   } rom_stage_type;

   typedef struct packed {
      carry_type           c;
      logic [COS_BITS-1:0] bias_l;
      logic [COS_BITS-1:0] bias_r;
   } interp_stage_type;

   typedef struct packed {
      carry_type            c;
      logic [COEF_BITS-1:0] hl;
      logic [COEF_BITS-1:0] hr;
   } coef_stage_type;

   typedef struct packed {
      carry_type          c;
      logic [HH_BITS-1:0] hh;
   } gain_stage_type;

   typedef struct packed {
      carry_type           c;
      logic [MUL_BITS-1:0] prod;
   } mul_stage_type;

   // cos of a q30 angle in [0, pi/2], taylor series up to x^16
   function automatic logic [63:0] cos_quarter_q30(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        mag;
      logic signed [64:0] sum;
      x2  = (x * x) >> 30;
      mag = Q30_ONE;
      sum = $signed({1'b0, Q30_ONE});
      for (int k = 1; k <= 8; k++) begin
         mag = ((mag * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
         if ((k % 2) == 1) begin
            sum = sum - $signed({1'b0, mag});
         end else begin
            sum = sum + $signed({1'b0, mag});
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      if (sum > $signed({1'b0, Q30_ONE})) begin
         sum = $signed({1'b0, Q30_ONE});
      end
      return sum[63:0];
   endfunction

   // one full cosine cycle, stored as cos + 1.0 in unsigned q2.16
   function automatic cos_rom_type build_cos_rom();
      cos_rom_type rom;
      logic [63:0] x;
      logic [63:0] c;
      logic        neg;
      for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
         x   = (TWO_PI_Q30 * 64'(i) + 64'(COS_TABLE_DEPTH / 2)) / 64'(COS_TABLE_DEPTH);
         neg = 1'b0;
         if (x > PI_Q30) begin
            x = TWO_PI_Q30 - x;
         end
         if (x > HALF_PI_Q30) begin
            x   = PI_Q30 - x;
            neg = 1'b1;
         end
         c = (cos_quarter_q30(x) + 64'd8192) >> 14;
         rom[i] = neg ? COS_BITS'(64'd65536 - c) : COS_BITS'(64'd65536 + c);
      end
      return rom;
   endfunction

endpackage

`default_nettype wire

// ===== design/hann_edge_taper.sv =====
// hann edge taper top level: config registers, phase divider pipeline, cosine lookup, scaling
//
// request channel: req_valid / req_stall with req_sample_value (signed) and
// req_sample_position; a request is taken at a clock edge with req_valid high
// and req_stall low. result channel: rsp_valid / rsp_stall with
// rsp_tapered_value, one result per request, in request order.
// registers on the csr port: trace_length at 0x0, left_fraction at 0x4,
// right_fraction at 0x8; write them only while no request is in flight.
// a result passes through the accept, region, phase divider, table, interpolation,
// coefficient, gain, product and output registers, held while the result channel stalls.
// throughput: one request per cycle unless the result channel stalls; the
// 27-step phase divider runs as a pipeline of one quotient bit per stage,
// and the cosine table has two read ports per window side.
// reset: registers return to 1024 / 3277 / 3277 and the pipeline empties.
// while a result is held by rsp_stall the whole pipeline freezes and
// req_stall is raised; nothing is lost or repeated.
`default_nettype none

module hann_edge_taper (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [het_pkg::SAMPLE_BITS-1:0] req_sample_value,
   input  logic        [het_pkg::POS_BITS-1:0]    req_sample_position,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [het_pkg::SAMPLE_BITS-1:0] rsp_tapered_value,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic        [het_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic        [het_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic        [het_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                   csr_pready
);
   import het_pkg::*;

   localparam cos_rom_type COS_ROM = build_cos_rom();

   logic [REG_BITS-1:0] trace_length_ff;
   logic [REG_BITS-1:0] left_fraction_ff;
   logic [REG_BITS-1:0] right_fraction_ff;
   logic                cfg_write;
   logic [1:0]          cfg_index;

   logic [REG_BITS-1:0] n_sat;
   logic                adv;

   accept_stage_type st1_ff, st1_in;
   div_stage_type    st2_ff, st2_in;
   div_stage_type    div_ff [DIV_STEPS];
   div_stage_type    div_in [DIV_STEPS];
   rom_stage_type    st3_ff;
   interp_stage_type st4_ff, st4_in;
   coef_stage_type   st5_ff, st5_in;
   gain_stage_type   st6_ff, st6_in;
   mul_stage_type    st7_ff, st7_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_value_ff, rsp_value_in;

   logic [REG_BITS-1:0]     lc, rc, pos_ext;
   logic [REG_BITS:0]       dl_sum, dr_sum;
   logic [REG_BITS+1:0]     kr_sum;
   logic                    on_l, on_r;
   logic [COS_IDX_BITS-1:0] idx_l0, idx_l1, idx_r0, idx_r1;
   logic [MUL_BITS-1:0]     rnd_sum;
   logic [SAMPLE_BITS-1:0]  rnd;

   // one restoring division step: shift in a numerator bit, subtract twice the denominator
   function automatic div_side_type div_step(input div_side_type s, input logic nbit);
      logic [REM_BITS:0] t;
      logic [REM_BITS:0] dd;
      div_side_type      o;
      t  = {s.rem, nbit};
      dd = {1'b0, s.den, 1'b0};
      o  = s;
      if (t >= dd) begin
         o.rem = REM_BITS'(t - dd);
         o.quo = {s.quo[PHASE_BITS-2:0], 1'b1};
      end else begin
         o.rem = t[REM_BITS-1:0];
         o.quo = {s.quo[PHASE_BITS-2:0], 1'b0};
      end
      return o;
   endfunction

   // linear interpolation between neighboring table entries, rounded half up
   function automatic logic [COS_BITS-1:0] interp_cos(input rom_side_type s);
      logic signed [COS_BITS:0]                   diff;
      logic signed [COS_BITS+PHASE_FRAC_BITS+1:0] prod;
      logic signed [COS_BITS+PHASE_FRAC_BITS+1:0] shifted;
      logic signed [COS_BITS+2:0]                 lerp;
      logic [COS_BITS-1:0]                        res;
      diff    = $signed({1'b0, s.b}) - $signed({1'b0, s.a});
      prod    = diff * $signed({1'b0, s.frac});
      prod    = prod + ROUND_FRAC;
      shifted = prod >>> PHASE_FRAC_BITS;
      lerp    = $signed({3'b000, s.a}) + $signed(shifted[COS_BITS+2:0]);
      if (lerp[COS_BITS+2]) begin
         res = '0;
      end else if (lerp > $signed({3'b000, BIAS_MAX})) begin
         res = BIAS_MAX;
      end else begin
         res = lerp[COS_BITS-1:0];
      end
      return res;
   endfunction

   // hann coefficient (1 - cos) / 2 from the biased cosine, or one outside the taper region
   function automatic logic [COEF_BITS-1:0] hann_coef(input logic on,
                                                      input logic [COS_BITS-1:0] bias);
      logic [COS_BITS:0]    t;
      logic [COEF_BITS-1:0] h;
      t = {1'b0, BIAS_MAX} + (COS_BITS + 1)'(1) - {1'b0, bias};
      h = on ? t[COS_BITS-1:1] : COEF_ONE;
      return h;
   endfunction

   // csr port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite;
   assign cfg_index  = csr_paddr[CSR_ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_length_ff   <= TRACE_LENGTH_RESET;
         left_fraction_ff  <= FRACTION_RESET;
         right_fraction_ff <= FRACTION_RESET;
      end else if (cfg_write) begin
         unique case (cfg_index)
            REG_TRACE_LENGTH:   trace_length_ff   <= csr_pwdata[REG_BITS-1:0];
            REG_LEFT_FRACTION:  left_fraction_ff  <= csr_pwdata[REG_BITS-1:0];
            REG_RIGHT_FRACTION: right_fraction_ff <= csr_pwdata[REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_index)
         REG_TRACE_LENGTH:   csr_prdata = CSR_DATA_BITS'(trace_length_ff);
         REG_LEFT_FRACTION:  csr_prdata = CSR_DATA_BITS'(left_fraction_ff);
         REG_RIGHT_FRACTION: csr_prdata = CSR_DATA_BITS'(right_fraction_ff);
         default:            csr_prdata = '0;
      endcase
   end

   assign n_sat = (trace_length_ff > MAX_TRACE_LEN) ? MAX_TRACE_LEN : trace_length_ff;

   // the whole pipeline moves unless a finished result is held
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // accept stage: sample plus taper count products
   always_comb begin
      st1_in.valid  = req_valid;
      st1_in.value  = req_sample_value;
      st1_in.pos    = req_sample_position;
      st1_in.prod_l = PROD_BITS'(n_sat) * PROD_BITS'(left_fraction_ff);
      st1_in.prod_r = PROD_BITS'(n_sat) * PROD_BITS'(right_fraction_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_ff.valid <= 1'b0;
      end else if (adv) begin
         st1_ff <= st1_in;
      end
   end

   // region stage: taper counts, membership, phase numerators and denominators
   always_comb begin
      lc = (st1_ff.prod_l[PROD_BITS-1:FRAC_BITS] > {1'b0, n_sat}) ? n_sat
         : st1_ff.prod_l[FRAC_BITS+REG_BITS-1:FRAC_BITS];
      rc = (st1_ff.prod_r[PROD_BITS-1:FRAC_BITS] > {1'b0, n_sat}) ? n_sat
         : st1_ff.prod_r[FRAC_BITS+REG_BITS-1:FRAC_BITS];
      pos_ext = {1'b0, st1_ff.pos};
      on_l    = (lc != '0) && (pos_ext < lc);
      on_r    = (rc != '0) && (pos_ext < n_sat) && (pos_ext >= n_sat - rc);
      dl_sum  = {lc, 1'b0} - (REG_BITS + 1)'(1);
      dr_sum  = {rc, 1'b0} - (REG_BITS + 1)'(1);
      kr_sum  = {2'b00, pos_ext} + {1'b0, rc, 1'b0} - {2'b00, n_sat};

      st2_in.c.valid = st1_ff.valid;
      st2_in.c.neg   = st1_ff.value[SAMPLE_BITS-1];
      st2_in.c.mag   = st1_ff.value[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - $unsigned(st1_ff.value))
                                                   : $unsigned(st1_ff.value);
      st2_in.c.on_l  = on_l;
      st2_in.c.on_r  = on_r;
      st2_in.l.rem   = on_l ? {1'b0, pos_ext} : '0;
      st2_in.l.den   = on_l ? dl_sum[REG_BITS-1:0] : REG_BITS'(1);
      st2_in.l.quo   = '0;
      st2_in.r.rem   = on_r ? {1'b0, kr_sum[REG_BITS-1:0]} : '0;
      st2_in.r.den   = on_r ? dr_sum[REG_BITS-1:0] : REG_BITS'(1);
      st2_in.r.quo   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_ff.c.valid <= 1'b0;
      end else if (adv) begin
         st2_ff <= st2_in;
      end
   end

   // phase divider, one quotient bit per stage; the low numerator bits are the denominator
   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
      localparam int NUM_BIT = DIV_STEPS - 1 - s;
      div_stage_type src;
      logic          nbit_l, nbit_r;

      if (s == 0) begin : g_first
         assign src = st2_ff;
      end else begin : g_next
         assign src = div_ff[s-1];
      end

      if (NUM_BIT < REG_BITS) begin : g_low
         assign nbit_l = src.l.den[NUM_BIT];
         assign nbit_r = src.r.den[NUM_BIT];
      end else begin : g_high
         assign nbit_l = 1'b0;
         assign nbit_r = 1'b0;
      end

      always_comb begin
         div_in[s].c = src.c;
         div_in[s].l = div_step(src.l, nbit_l);
         div_in[s].r = div_step(src.r, nbit_r);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[s].c.valid <= 1'b0;
         end else if (adv) begin
            div_ff[s] <= div_in[s];
         end
      end
   end

   // cosine table, two registered reads per side
   always_comb begin
      idx_l0 = div_ff[DIV_STEPS-1].l.quo[PHASE_BITS-1:PHASE_FRAC_BITS];
      idx_r0 = div_ff[DIV_STEPS-1].r.quo[PHASE_BITS-1:PHASE_FRAC_BITS];
      idx_l1 = idx_l0 + COS_IDX_BITS'(1);
      idx_r1 = idx_r0 + COS_IDX_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st3_ff.c.valid <= 1'b0;
      end else if (adv) begin
         st3_ff.c      <= div_ff[DIV_STEPS-1].c;
         st3_ff.l.a    <= COS_ROM[idx_l0];
         st3_ff.l.b    <= COS_ROM[idx_l1];
         st3_ff.l.frac <= div_ff[DIV_STEPS-1].l.quo[PHASE_FRAC_BITS-1:0];
         st3_ff.r.a    <= COS_ROM[idx_r0];
         st3_ff.r.b    <= COS_ROM[idx_r1];
         st3_ff.r.frac <= div_ff[DIV_STEPS-1].r.quo[PHASE_FRAC_BITS-1:0];
      end
   end

   always_comb begin
      st4_in.c      = st3_ff.c;
      st4_in.bias_l = interp_cos(st3_ff.l);
      st4_in.bias_r = interp_cos(st3_ff.r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st4_ff.c.valid <= 1'b0;
      end else if (adv) begin
         st4_ff <= st4_in;
      end
   end

   always_comb begin
      st5_in.c  = st4_ff.c;
      st5_in.hl = hann_coef(st4_ff.c.on_l, st4_ff.bias_l);
      st5_in.hr = hann_coef(st4_ff.c.on_r, st4_ff.bias_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st5_ff.c.valid <= 1'b0;
      end else if (adv) begin
         st5_ff <= st5_in;
      end
   end

   always_comb begin
      st6_in.c  = st5_ff.c;
      st6_in.hh = HH_BITS'(st5_ff.hl * st5_ff.hr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st6_ff.c.valid <= 1'b0;
      end else if (adv) begin
         st6_ff <= st6_in;
      end
   end

   always_comb begin
      st7_in.c    = st6_ff.c;
      st7_in.prod = MUL_BITS'(st6_ff.c.mag) * MUL_BITS'(st6_ff.hh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st7_ff.c.valid <= 1'b0;
      end else if (adv) begin
         st7_ff <= st7_in;
      end
   end

   // round half away from zero on the magnitude, then restore the sign
   always_comb begin
      rnd_sum      = st7_ff.prod + (MUL_BITS'(1) << 31);
      rnd          = rnd_sum[SAMPLE_BITS+31:32];
      rsp_valid_in = st7_ff.c.valid;
      rsp_value_in = st7_ff.c.neg ? $signed(SAMPLE_BITS'(0) - rnd) : $signed(rnd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tapered_value = rsp_value_ff;

   a_hold_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("held result does not stall the request side");

   a_coef_range: assert property (@(posedge clock) disable iff (reset)
      st5_ff.c.valid |-> ((st5_ff.hl <= COEF_ONE) && (st5_ff.hr <= COEF_ONE)))
      else $error("hann coefficient above one");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      div_ff[DIV_STEPS-1].c.valid |->
         ((div_ff[DIV_STEPS-1].l.rem < {div_ff[DIV_STEPS-1].l.den, 1'b0}) &&
          (div_ff[DIV_STEPS-1].r.rem < {div_ff[DIV_STEPS-1].r.den, 1'b0})))
      else $error("phase divider remainder out of range");

endmodule

`default_nettype wire
